// ===== sv/ssra_pkg.sv =====
// Shared types and constants for the shared segment reader arbiter.
package ssra_pkg;

    localparam int CLIENTS      = 8;
    localparam int SEGMENT_BITS = 16;
    localparam int CLIENT_W     = $clog2(CLIENTS);
    localparam int PTR_W        = $clog2(CLIENTS);
    localparam int CNT_W        = $clog2(CLIENTS + 1);
    localparam int READER_W     = 4;
    localparam int ENTRY_W      = CLIENT_W + SEGMENT_BITS;

    localparam logic [READER_W-1:0] READERS_MAX = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DOWN,
        S_FLUSH,
        S_UP
    } t_state;

    typedef enum logic {
        NK_ACK   = 1'b0,
        NK_GRANT = 1'b1
    } t_kind;

    typedef struct packed {
        logic [CLIENT_W-1:0]     client;
        logic [SEGMENT_BITS-1:0] segment;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [PTR_W-1:0] raddr;
    } t_ram_req;

endpackage

// ===== sv/ssra_stack_ram.sv =====
// Simple dual-port RAM with registered read data, holding the pending stack.
module ssra_stack_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ssra_ctrl.sv =====
// Request handling, grant scan and stack compaction sequencer.
module ssra_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ssra_pkg::CLIENT_W-1:0]       i_requesting_client,
    input  logic                                i_is_release,
    input  logic [ssra_pkg::SEGMENT_BITS-1:0]   i_wanted_segment,
    input  logic                                i_request_valid,
    output ssra_pkg::t_ram_req                  o_ram,
    input  ssra_pkg::t_entry                    i_rdata,
    output logic                                o_strobe,
    output logic [ssra_pkg::CLIENT_W-1:0]       o_notify_client,
    output logic                                o_notice_kind,
    output logic                                o_load_segment,
    output logic [ssra_pkg::SEGMENT_BITS-1:0]   o_buffer_segment,
    output logic                                o_bad_request,
    output logic                                o_last_notice
);
    import ssra_pkg::*;

    t_state                  r_state, n_state;
    logic [SEGMENT_BITS-1:0] r_loaded_seg, n_loaded_seg;
    logic                    r_loaded_valid, n_loaded_valid;
    logic [READER_W-1:0]     r_readers, n_readers;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [PTR_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_w, n_w;
    logic [SEGMENT_BITS-1:0] r_top, n_top;
    logic                    r_first, n_first;
    t_entry                  r_held, n_held;
    logic                    r_held_load, n_held_load;

    logic                    r_strobe, n_strobe;
    logic [CLIENT_W-1:0]     r_client, n_client;
    logic                    r_kind, n_kind;
    logic                    r_load, n_load;
    logic [SEGMENT_BITS-1:0] r_buffer, n_buffer;
    logic                    r_bad, n_bad;
    logic                    r_last, n_last;

    logic [SEGMENT_BITS-1:0] seg_eff;
    logic [READER_W-1:0]     readers_dec;
    logic [READER_W-1:0]     readers_inc;
    logic                    scan;
    logic                    match;
    logic                    do_load;
    logic                    bad;
    logic                    hit;
    logic [PTR_W-1:0]        idx_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_loaded_seg   <= '0;
            r_loaded_valid <= 1'b0;
            r_readers      <= '0;
            r_count        <= '0;
            r_strobe       <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_loaded_seg   <= n_loaded_seg;
            r_loaded_valid <= n_loaded_valid;
            r_readers      <= n_readers;
            r_count        <= n_count;
            r_strobe       <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_w         <= n_w;
        r_top       <= n_top;
        r_first     <= n_first;
        r_held      <= n_held;
        r_held_load <= n_held_load;
        r_client    <= n_client;
        r_kind      <= n_kind;
        r_load      <= n_load;
        r_buffer    <= n_buffer;
        r_bad       <= n_bad;
        r_last      <= n_last;
    end

    always_comb begin
        n_state        = r_state;
        n_loaded_seg   = r_loaded_seg;
        n_loaded_valid = r_loaded_valid;
        n_readers      = r_readers;
        n_count        = r_count;
        n_idx          = r_idx;
        n_w            = r_w;
        n_top          = r_top;
        n_first        = r_first;
        n_held         = r_held;
        n_held_load    = r_held_load;

        n_strobe = 1'b0;
        n_client = r_client;
        n_kind   = r_kind;
        n_load   = r_load;
        n_buffer = r_buffer;
        n_bad    = r_bad;
        n_last   = r_last;

        o_ram = '0;

        seg_eff     = i_request_valid ? i_wanted_segment : '0;
        readers_dec = (r_readers != '0) ? r_readers - 1'b1 : '0;
        readers_inc = (r_readers == READERS_MAX) ? r_readers : r_readers + 1'b1;
        scan        = (readers_dec == '0) && (r_count != '0);
        match       = r_loaded_valid && (seg_eff == r_loaded_seg);
        do_load     = !match && (r_count == '0) && (r_readers == '0);
        bad         = !i_request_valid;
        hit         = r_first || (i_rdata.segment == r_top);
        idx_last    = PTR_W'(r_count - 1'b1);

        unique case (r_state)
            S_IDLE: begin
                if (start && i_is_release) begin
                    n_readers = readers_dec;
                    n_strobe  = 1'b1;
                    n_client  = i_requesting_client;
                    n_kind    = NK_ACK;
                    n_load    = 1'b0;
                    n_buffer  = r_loaded_seg;
                    n_bad     = 1'b0;
                    n_last    = !scan;
                    if (scan) begin
                        // fetch the top entry to open the grant scan
                        o_ram.re    = 1'b1;
                        o_ram.raddr = idx_last;
                        n_idx       = idx_last;
                        n_first     = 1'b1;
                        n_state     = S_DOWN;
                    end
                end else if (start) begin
                    if (match || do_load) begin
                        n_loaded_seg   = seg_eff;
                        n_loaded_valid = 1'b1;
                        n_readers      = readers_inc;
                        n_strobe       = 1'b1;
                        n_client       = i_requesting_client;
                        n_kind         = NK_GRANT;
                        n_load         = do_load;
                        n_buffer       = seg_eff;
                        n_bad          = bad;
                        n_last         = 1'b1;
                    end else begin
                        if (r_count < CNT_W'(CLIENTS)) begin
                            o_ram.we            = 1'b1;
                            o_ram.waddr         = r_count[PTR_W-1:0];
                            o_ram.wdata.client  = i_requesting_client;
                            o_ram.wdata.segment = seg_eff;
                            n_count             = r_count + 1'b1;
                        end else begin
                            // stack full: drop the beat
                            bad = 1'b1;
                        end
                        if (bad) begin
                            n_strobe = 1'b1;
                            n_client = i_requesting_client;
                            n_kind   = NK_ACK;
                            n_load   = 1'b0;
                            n_buffer = r_loaded_seg;
                            n_bad    = 1'b1;
                            n_last   = 1'b1;
                        end
                    end
                end
            end

            S_DOWN: begin
                n_first = 1'b0;
                if (r_first) begin
                    n_top          = i_rdata.segment;
                    n_loaded_seg   = i_rdata.segment;
                    n_loaded_valid = 1'b1;
                end
                if (hit) begin
                    n_readers = readers_inc;
                    // hold each grant until the next hit so the last one can be marked
                    if (!r_first) begin
                        n_strobe = 1'b1;
                        n_client = r_held.client;
                        n_kind   = NK_GRANT;
                        n_load   = r_held_load;
                        n_buffer = r_loaded_seg;
                        n_bad    = 1'b0;
                        n_last   = 1'b0;
                    end
                    n_held      = i_rdata;
                    n_held_load = r_first;
                end
                if (r_idx == '0) begin
                    n_state = S_FLUSH;
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_idx - 1'b1;
                    n_idx       = r_idx - 1'b1;
                end
            end

            S_FLUSH: begin
                n_strobe    = 1'b1;
                n_client    = r_held.client;
                n_kind      = NK_GRANT;
                n_load      = r_held_load;
                n_buffer    = r_loaded_seg;
                n_bad       = 1'b0;
                n_last      = 1'b1;
                o_ram.re    = 1'b1;
                o_ram.raddr = '0;
                n_idx       = '0;
                n_w         = '0;
                n_state     = S_UP;
            end

            S_UP: begin
                // compact survivors downwards, bottom first
                if (i_rdata.segment != r_top) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_w[PTR_W-1:0];
                    o_ram.wdata = i_rdata;
                    n_w         = r_w + 1'b1;
                end
                if (r_idx == idx_last) begin
                    n_count = (i_rdata.segment != r_top) ? r_w + 1'b1 : r_w;
                    n_state = S_IDLE;
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_idx + 1'b1;
                    n_idx       = r_idx + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy             = (r_state != S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_notify_client  = r_client;
    assign o_notice_kind    = r_kind;
    assign o_load_segment   = r_load;
    assign o_buffer_segment = r_buffer;
    assign o_bad_request    = r_bad;
    assign o_last_notice    = r_last;

endmodule

// ===== sv/shared_segment_reader_arbiter_top.sv =====
// Top level of the shared segment reader arbiter.
//
// Usage: a message beat is taken on a rising edge with start high and busy
// low; it carries the client, release/want flag, wanted segment and a valid
// flag. Each notice appears on the o_ ports for exactly one cycle with
// o_strobe high; o_last_notice marks the final notice of a beat. The receiver
// cannot stall, so every notice must be taken when it is shown.
// A want leaves busy low: its notice, if any, appears in the cycle after the
// beat, so wants may arrive back to back.
// A release is acknowledged in the cycle after the beat. When it frees the
// buffer with requests stacked, busy rises and the pending stack RAM is
// walked twice at one entry per cycle: top to bottom to issue grants (each
// held until the next hit, so the last can be marked), then bottom to top to
// close the gaps, before the next beat is taken.
// Reset is synchronous and active low: no segment loaded, no readers, empty
// stack. The stack RAM is not cleared; only entries below the fill count are
// ever read.
module shared_segment_reader_arbiter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ssra_pkg::CLIENT_W-1:0]       i_requesting_client,
    input  logic                                i_is_release,
    input  logic [ssra_pkg::SEGMENT_BITS-1:0]   i_wanted_segment,
    input  logic                                i_request_valid,
    output logic                                o_strobe,
    output logic [ssra_pkg::CLIENT_W-1:0]       o_notify_client,
    output logic                                o_notice_kind,
    output logic                                o_load_segment,
    output logic [ssra_pkg::SEGMENT_BITS-1:0]   o_buffer_segment,
    output logic                                o_bad_request,
    output logic                                o_last_notice
);
    import ssra_pkg::*;

    t_ram_req           ram_req;
    logic [ENTRY_W-1:0] ram_rdata;

    ssra_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_requesting_client (i_requesting_client),
        .i_is_release        (i_is_release),
        .i_wanted_segment    (i_wanted_segment),
        .i_request_valid     (i_request_valid),
        .o_ram               (ram_req),
        .i_rdata             (ram_rdata),
        .o_strobe            (o_strobe),
        .o_notify_client     (o_notify_client),
        .o_notice_kind       (o_notice_kind),
        .o_load_segment      (o_load_segment),
        .o_buffer_segment    (o_buffer_segment),
        .o_bad_request       (o_bad_request),
        .o_last_notice       (o_last_notice)
    );

    ssra_stack_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CLIENTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    // a notice that is not the last of its beat only comes during a scan
    a_more_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_notice |-> busy)
        else $error("non-final notice outside a grant scan");

    // a segment load is only ever reported on a grant
    a_load_on_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_load_segment |-> o_notice_kind == NK_GRANT)
        else $error("segment load flagged on a non-grant notice");

    // a malformed want always yields one flagged notice
    a_bad_want_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_is_release && !i_request_valid
        |=> o_strobe && o_bad_request && o_last_notice)
        else $error("malformed want not flagged");

    // the stack RAM is never written while an entry is being fetched below it
    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.we && ram_req.re && busy |-> ram_req.waddr <= ram_req.raddr)
        else $error("compaction write overtook the read pointer");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the shared segment reader arbiter: directed and random message beats.
module testbench;
    import ssra_pkg::*;

    typedef struct {
        logic [CLIENT_W-1:0]     client;
        logic                    is_rel;
        logic [SEGMENT_BITS-1:0] seg;
        logic                    valid;
        int                      idle_pct;
    } t_message;

    typedef struct {
        logic [CLIENT_W-1:0]     client;
        t_kind                   kind;
        logic                    load;
        logic [SEGMENT_BITS-1:0] seg;
        logic                    bad;
        logic                    last;
    } t_notice;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [CLIENT_W-1:0]     i_requesting_client = '0;
    logic                    i_is_release = 1'b0;
    logic [SEGMENT_BITS-1:0] i_wanted_segment = '0;
    logic                    i_request_valid = 1'b0;
    logic                    o_strobe;
    logic [CLIENT_W-1:0]     o_notify_client;
    logic                    o_notice_kind;
    logic                    o_load_segment;
    logic [SEGMENT_BITS-1:0] o_buffer_segment;
    logic                    o_bad_request;
    logic                    o_last_notice;

    shared_segment_reader_arbiter_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_requesting_client (i_requesting_client),
        .i_is_release        (i_is_release),
        .i_wanted_segment    (i_wanted_segment),
        .i_request_valid     (i_request_valid),
        .o_strobe            (o_strobe),
        .o_notify_client     (o_notify_client),
        .o_notice_kind       (o_notice_kind),
        .o_load_segment      (o_load_segment),
        .o_buffer_segment    (o_buffer_segment),
        .o_bad_request       (o_bad_request),
        .o_last_notice       (o_last_notice)
    );

    t_message message_q[$];
    t_notice  notice_q[$];
    t_notice  batch[$];
    t_message cur_msg;
    int       beats_total = 0;
    int       beats_taken = 0;
    int       errors = 0;

    // Arbiter state as the bench sees it
    logic [SEGMENT_BITS-1:0] buf_seg = '0;
    logic                    buf_loaded = 1'b0;
    logic [READER_W-1:0]     reader_cnt = '0;
    t_entry                  wait_stack [CLIENTS];
    int                      wait_depth = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
        errors++;
        $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    task automatic post(input logic [CLIENT_W-1:0] client, input t_kind kind,
                        input logic load, input logic bad);
        t_notice n;
        n.client = client;
        n.kind   = kind;
        n.load   = load;
        n.seg    = buf_seg;
        n.bad    = bad;
        n.last   = 1'b0;
        batch.push_back(n);
    endtask

    task automatic add_reader();
        if (reader_cnt != READERS_MAX)
            reader_cnt++;
    endtask

    // Work out the notices that one accepted beat causes
    task automatic arbitrate(input t_message m);
        logic [SEGMENT_BITS-1:0] seg;
        logic [SEGMENT_BITS-1:0] top;
        logic                    bad;
        logic                    load;
        int                      i;
        int                      j;
        batch.delete();
        if (m.is_rel) begin
            if (reader_cnt != 0)
                reader_cnt--;
            post(m.client, NK_ACK, 1'b0, 1'b0);
            if (reader_cnt == 0 && wait_depth > 0) begin
                top        = wait_stack[wait_depth-1].segment;
                buf_seg    = top;
                buf_loaded = 1'b1;
                load       = 1'b1;
                // scan top to bottom, grant and remove every entry for the new segment
                for (i = wait_depth - 1; i >= 0; i--) begin
                    if (wait_stack[i].segment == top) begin
                        post(wait_stack[i].client, NK_GRANT, load, 1'b0);
                        load = 1'b0;
                        add_reader();
                        for (j = i; j < wait_depth - 1; j++)
                            wait_stack[j] = wait_stack[j+1];
                        wait_depth--;
                    end
                end
            end
        end else begin
            seg  = m.valid ? m.seg : '0;
            bad  = !m.valid;
            load = 1'b0;
            if (wait_depth == 0 && reader_cnt == 0 && !(buf_loaded && seg == buf_seg)) begin
                buf_seg    = seg;
                buf_loaded = 1'b1;
                load       = 1'b1;
            end
            if (buf_loaded && seg == buf_seg) begin
                add_reader();
                post(m.client, NK_GRANT, load, bad);
            end else begin
                if (wait_depth < CLIENTS) begin
                    wait_stack[wait_depth].client  = m.client;
                    wait_stack[wait_depth].segment = seg;
                    wait_depth++;
                end else begin
                    bad = 1'b1;
                end
                if (bad)
                    post(m.client, NK_ACK, 1'b0, 1'b1);
            end
        end
        if (batch.size() > 0) begin
            batch[batch.size()-1].last = 1'b1;
            foreach (batch[k])
                notice_q.push_back(batch[k]);
        end
    endtask

    task automatic queue_msg(input int client, input logic is_rel, input logic [31:0] seg,
                             input logic valid, input int idle_pct);
        t_message m;
        m.client   = client[CLIENT_W-1:0];
        m.is_rel   = is_rel;
        m.seg      = seg[SEGMENT_BITS-1:0];
        m.valid    = valid;
        m.idle_pct = idle_pct;
        message_q.push_back(m);
    endtask

    function automatic logic [31:0] pick_seg();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return $urandom;
        else if (r == 1)
            return $urandom_range(0, 3);
        else if (r == 2)
            return 32'hFFFF;
        return 32'h0;
    endfunction

    // Driver: hold a beat until taken, then present the next or idle
    always @(posedge i_clk) begin : drive
        logic taken;
        taken = start && !busy;
        if (taken) begin
            arbitrate(cur_msg);
            beats_taken++;
        end
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !taken) begin
            // hold the beat
        end else if (message_q.size() > 0 &&
                     $urandom_range(0, 99) >= message_q[0].idle_pct) begin
            cur_msg             = message_q.pop_front();
            start               <= 1'b1;
            i_requesting_client <= cur_msg.client;
            i_is_release        <= cur_msg.is_rel;
            i_wanted_segment    <= cur_msg.seg;
            i_request_valid     <= cur_msg.valid;
        end else begin
            start               <= 1'b0;
            i_requesting_client <= CLIENT_W'($urandom);
            i_is_release        <= 1'($urandom);
            i_wanted_segment    <= SEGMENT_BITS'($urandom);
            i_request_valid     <= 1'($urandom);
        end
    end

    // Monitor: every strobed notice must match the oldest expectation
    always @(posedge i_clk) begin : watch
        t_notice e;
        if (i_rst_n && o_strobe) begin
            if (notice_q.size() == 0) begin
                flag("unexpected notice to client", 32'h0, 32'(o_notify_client));
            end else begin
                e = notice_q.pop_front();
                if (o_notify_client !== e.client)
                    flag("notify_client", 32'(e.client), 32'(o_notify_client));
                if (o_notice_kind !== logic'(e.kind))
                    flag("notice_kind", 32'(e.kind), 32'(o_notice_kind));
                if (o_load_segment !== e.load)
                    flag("load_segment", 32'(e.load), 32'(o_load_segment));
                if (o_buffer_segment !== e.seg)
                    flag("buffer_segment", 32'(e.seg), 32'(o_buffer_segment));
                if (o_bad_request !== e.bad)
                    flag("bad_request", 32'(e.bad), 32'(o_bad_request));
                if (o_last_notice !== e.last)
                    flag("last_notice", 32'(e.last), 32'(o_last_notice));
            end
        end
    end

    initial begin : stimulus
        int phase_pct [4];
        logic [31:0] pool [3];
        int pct;
        int kind;
        int len;
        int rp;
        int n;
        int cnt;
        logic [31:0] s;
        phase_pct[0] = 0;
        phase_pct[1] = 82;
        phase_pct[2] = 0;
        phase_pct[3] = 10;

        // release with no readers, invalid want on an empty buffer, plain grant
        queue_msg(0, 1, 32'hFFFF, 0, 0);
        queue_msg(7, 0, 32'hFFFF, 0, 0);
        queue_msg(1, 0, 32'h0000, 1, 0);
        queue_msg(2, 0, 32'hFFFF, 1, 0);
        queue_msg(3, 0, 32'h1234, 1, 0);
        queue_msg(4, 0, 32'hFFFF, 1, 0);
        queue_msg(5, 0, 32'hAAAA, 0, 0);
        queue_msg(7, 1, 32'h0, 1, 0);
        queue_msg(1, 1, 32'h0, 1, 0);
        queue_msg(5, 1, 32'h0, 1, 0);
        // invalid want that gets stacked, then fill the stack and overflow it
        queue_msg(6, 0, 32'h5A5A, 0, 0);
        queue_msg(0, 0, 32'h5555, 1, 0);
        queue_msg(1, 0, 32'h8000, 1, 0);
        queue_msg(2, 0, 32'h0001, 1, 0);
        queue_msg(3, 0, 32'h5555, 1, 0);
        queue_msg(5, 0, 32'h7FFF, 1, 0);
        queue_msg(7, 0, 32'h5555, 1, 0);
        queue_msg(0, 0, 32'h4444, 1, 0);
        queue_msg(1, 0, 32'hFFFF, 1, 0);
        queue_msg(4, 1, 32'h0, 1, 0);
        queue_msg(2, 1, 32'h0, 1, 0);
        queue_msg(1, 1, 32'h0, 1, 0);
        queue_msg(7, 1, 32'h0, 1, 0);
        queue_msg(3, 1, 32'h0, 1, 0);
        queue_msg(0, 1, 32'h0, 1, 0);

        cnt = message_q.size();
        while (cnt < 380) begin
            pct  = phase_pct[(cnt / 95) % 4];
            kind = $urandom_range(0, 9);
            for (int k = 0; k < 3; k++)
                pool[k] = pick_seg();
            if (kind < 7) begin
                // mixed traffic over a small set of segments
                len = $urandom_range(10, 30);
                rp  = $urandom_range(15, 70);
                for (n = 0; n < len; n++) begin
                    s = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 2)];
                    queue_msg($urandom_range(0, 7), $urandom_range(0, 99) < rp, s,
                              $urandom_range(0, 11) != 0, pct);
                end
                cnt += len;
            end else if (kind < 9) begin
                // pile wants for one segment behind a reader, then release them all
                queue_msg($urandom_range(0, 7), 0, pool[0], 1, pct);
                for (n = 0; n < 9; n++)
                    queue_msg($urandom_range(0, 7), 0, pool[1] ^ 32'h1, 1, pct);
                for (n = 0; n < 12; n++)
                    queue_msg($urandom_range(0, 7), 1, $urandom, 1'($urandom), pct);
                cnt += 22;
            end else begin
                // drain everything, then flood one segment past reader saturation
                for (n = 0; n < 24; n++)
                    queue_msg($urandom_range(0, 7), 1, $urandom, 1'($urandom), pct);
                for (n = 0; n < 18; n++)
                    queue_msg($urandom_range(0, 7), 0, pool[2], 1, pct);
                for (n = 0; n < 18; n++)
                    queue_msg($urandom_range(0, 7), 1, $urandom, 1'($urandom), pct);
                cnt += 60;
            end
        end
        beats_total = message_q.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_taken < beats_total)
            @(posedge i_clk);
        while (notice_q.size() != 0)
            @(posedge i_clk);
        // allow a full stack walk for any stray notice
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
